### hdl/pfc_pkg.sv
// Shared types and constants for the pixel format converter.
// Holds the format codes, the RGBA8 pixel type and the pipeline control type.
// No dependencies.
`default_nettype none

package pfc_pkg;

    // Pixel format codes, as held in the configuration registers.
    typedef enum logic [2:0] {
        FMT_RGBA8   = 3'd0,
        FMT_RGBA4   = 3'd1,
        FMT_RGB5_A1 = 3'd2,
        FMT_RGB565  = 3'd3,
        FMT_LA88    = 3'd4,
        FMT_L8      = 3'd5
    } pfc_format_t;

    // Configuration register indexes.
    localparam logic CFG_SOURCE_FORMAT = 1'b0;
    localparam logic CFG_TARGET_FORMAT = 1'b1;

    // Byte counts of the packed formats.
    localparam logic [2:0] BYTES_FOUR = 3'd4;
    localparam logic [2:0] BYTES_TWO  = 3'd2;
    localparam logic [2:0] BYTES_ONE  = 3'd1;

    // Reciprocal of three for sums below 2048: x / 3 == (x * 683) >> 11.
    localparam logic [9:0] RECIP_THREE = 10'd683;
    localparam int unsigned RECIP_SHIFT = 11;

    // Channel value used where a format carries no alpha.
    localparam logic [7:0] CHAN_FULL = 8'hff;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pfc_pixel_t;

    // Control that travels alongside each beat through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } pfc_ctrl_t;

endpackage : pfc_pkg

`default_nettype wire

### hdl/pixel_format_converter.sv
// Pixel format converter: a four-stage pipeline that takes one pixel a cycle.
// A pixel is accepted on any cycle with start high (busy is never raised) and its
// result leaves the pack stage with done high for exactly one cycle; the
// receiver cannot stall it. The stages are expand, sum,
// reciprocal multiply for the luminance divide by three, and pack. Formats are
// written through cfg_we, cfg_index and cfg_data. The source format is applied as a
// pixel is accepted and the target format only when it reaches the pack stage, so
// write them only while no pixel is in flight.
// Top level; depends on pfc_pkg, pfc_expand, pfc_lum and pfc_pack.
`default_nettype none

module pixel_format_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [2:0]  cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] src_word,
    input  wire logic        last_in,
    output logic             done,
    output logic [31:0]      dst_word,
    output logic [2:0]       dst_byte_count,
    output logic             last_out
);
    import pfc_pkg::*;

    logic [2:0] source_format_reg;
    logic [2:0] source_format_next;
    logic [2:0] target_format_reg;
    logic [2:0] target_format_next;
    pfc_ctrl_t  ctrl_in;
    pfc_ctrl_t  ctrl_s1;
    pfc_ctrl_t  ctrl_s3;
    pfc_pixel_t px_s1;
    pfc_pixel_t px_s3;
    logic [7:0] lum_s3;

    // The pipeline never stalls, so a beat is taken on every start.
    assign busy    = 1'b0;
    assign ctrl_in = '{valid: start & ~busy, last: last_in};

    // Configuration register writes.
    always_comb
    begin
        source_format_next = source_format_reg;
        target_format_next = target_format_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_FORMAT: source_format_next = cfg_data;
                CFG_TARGET_FORMAT: target_format_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= FMT_RGBA8;
            target_format_reg <= FMT_RGBA8;
        end
        else
        begin
            source_format_reg <= source_format_next;
            target_format_reg <= target_format_next;
        end
    end

    pfc_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_fmt  (source_format_reg),
        .word_in  (src_word),
        .ctrl_in  (ctrl_in),
        .px_out   (px_s1),
        .ctrl_out (ctrl_s1)
    );

    pfc_lum u_lum (
        .clk      (clk),
        .rst_n    (rst_n),
        .px_in    (px_s1),
        .ctrl_in  (ctrl_s1),
        .px_out   (px_s3),
        .ctrl_out (ctrl_s3),
        .lum_out  (lum_s3)
    );

    pfc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .dst_fmt   (target_format_reg),
        .px_in     (px_s3),
        .ctrl_in   (ctrl_s3),
        .lum_in    (lum_s3),
        .valid_out (done),
        .word_out  (dst_word),
        .count_out (dst_byte_count),
        .last_out  (last_out)
    );

`ifndef SYNTHESIS
    // Every result beat comes from a pixel accepted earlier.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result beat without a matching accepted pixel");

    // The byte count is always one, two or four.
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dst_byte_count == BYTES_ONE || dst_byte_count == BYTES_TWO ||
                  dst_byte_count == BYTES_FOUR))
        else $error("illegal byte count");

    // Bytes beyond a two-byte result are zero.
    a_two_byte_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dst_byte_count == BYTES_TWO) |-> (dst_word[31:16] == 16'h0))
        else $error("upper bytes of two-byte result not zero");

    // Bytes beyond a one-byte result are zero.
    a_one_byte_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dst_byte_count == BYTES_ONE) |-> (dst_word[31:8] == 24'h0))
        else $error("upper bytes of one-byte result not zero");
`endif

endmodule : pixel_format_converter

`default_nettype wire

### hdl/pfc_expand.sv
// First pipeline stage: expands the source word to an RGBA8 pixel.
// Depends on pfc_pkg.
`default_nettype none

module pfc_expand (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         src_fmt,
    input  wire logic [31:0]        word_in,
    input  wire pfc_pkg::pfc_ctrl_t ctrl_in,
    output pfc_pkg::pfc_pixel_t     px_out,
    output pfc_pkg::pfc_ctrl_t      ctrl_out
);
    import pfc_pkg::*;

    pfc_pixel_t px_next;
    pfc_pixel_t px_reg;
    pfc_ctrl_t  ctrl_reg;
    logic [15:0] half;

    assign half = word_in[15:0];

    // Narrow channels shift up zero-filled, 1-bit alpha replicates; luminance feeds RGB.
    always_comb
    begin
        unique case (pfc_format_t'(src_fmt))
            FMT_RGBA8:
            begin
                px_next = '{r: word_in[7:0], g: word_in[15:8],
                            b: word_in[23:16], a: word_in[31:24]};
            end
            FMT_RGBA4:
            begin
                px_next = '{r: {half[15:12], 4'b0}, g: {half[11:8], 4'b0},
                            b: {half[7:4], 4'b0}, a: {half[3:0], 4'b0}};
            end
            FMT_RGB5_A1:
            begin
                px_next = '{r: {half[15:11], 3'b0}, g: {half[10:6], 3'b0},
                            b: {half[5:1], 3'b0}, a: {8{half[0]}}};
            end
            FMT_RGB565:
            begin
                px_next = '{r: {half[15:11], 3'b0}, g: {half[10:5], 2'b0},
                            b: {half[4:0], 3'b0}, a: CHAN_FULL};
            end
            FMT_LA88:
            begin
                px_next = '{r: half[7:0], g: half[7:0], b: half[7:0], a: half[15:8]};
            end
            FMT_L8:
            begin
                px_next = '{r: half[7:0], g: half[7:0], b: half[7:0], a: CHAN_FULL};
            end
            default:
            begin
                px_next = '0;
            end
        endcase
    end

    // Payload needs no reset; the valid bit does.
    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign px_out   = px_reg;
    assign ctrl_out = ctrl_reg;

endmodule : pfc_expand

`default_nettype wire

### hdl/pfc_lum.sv
// Second and third pipeline stages: luminance as (R+G+B)/3, rounded down.
// The sum is registered, then divided by a reciprocal multiply. Depends on pfc_pkg.
`default_nettype none

module pfc_lum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pfc_pkg::pfc_pixel_t px_in,
    input  wire pfc_pkg::pfc_ctrl_t  ctrl_in,
    output pfc_pkg::pfc_pixel_t      px_out,
    output pfc_pkg::pfc_ctrl_t       ctrl_out,
    output logic [7:0]               lum_out
);
    import pfc_pkg::*;

    logic [9:0]  sum_next;
    logic [9:0]  sum_reg;
    logic [19:0] prod;
    logic [7:0]  lum_next;
    logic [7:0]  lum_reg;
    pfc_pixel_t  px_s2_reg;
    pfc_pixel_t  px_s3_reg;
    pfc_ctrl_t   ctrl_s2_reg;
    pfc_ctrl_t   ctrl_s3_reg;

    // Stage two: add the three colour channels.
    assign sum_next = {2'b0, px_in.r} + {2'b0, px_in.g} + {2'b0, px_in.b};

    // Stage three: divide by three; exact for every sum below 2048.
    assign prod     = sum_reg * RECIP_THREE;
    assign lum_next = prod[RECIP_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        px_s2_reg <= px_in;
        lum_reg   <= lum_next;
        px_s3_reg <= px_s2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_s2_reg <= '0;
            ctrl_s3_reg <= '0;
        end
        else
        begin
            ctrl_s2_reg <= ctrl_in;
            ctrl_s3_reg <= ctrl_s2_reg;
        end
    end

    assign px_out   = px_s3_reg;
    assign ctrl_out = ctrl_s3_reg;
    assign lum_out  = lum_reg;

endmodule : pfc_lum

`default_nettype wire

### hdl/pfc_pack.sv
// Fourth pipeline stage: packs the RGBA8 pixel into the target format.
// Registers the result beat and its strobe. Depends on pfc_pkg.
`default_nettype none

module pfc_pack (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          dst_fmt,
    input  wire pfc_pkg::pfc_pixel_t px_in,
    input  wire pfc_pkg::pfc_ctrl_t  ctrl_in,
    input  wire logic [7:0]          lum_in,
    output logic                     valid_out,
    output logic [31:0]              word_out,
    output logic [2:0]               count_out,
    output logic                     last_out
);
    import pfc_pkg::*;

    logic [31:0] word_next;
    logic [2:0]  count_next;
    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic        valid_reg;

    // Truncate each channel to the target width; unused bytes stay zero.
    always_comb
    begin
        unique case (pfc_format_t'(dst_fmt))
            FMT_RGBA4:
            begin
                word_next  = {16'b0, px_in.r[7:4], px_in.g[7:4], px_in.b[7:4], px_in.a[7:4]};
                count_next = BYTES_TWO;
            end
            FMT_RGB5_A1:
            begin
                word_next  = {16'b0, px_in.r[7:3], px_in.g[7:3], px_in.b[7:3], px_in.a[7]};
                count_next = BYTES_TWO;
            end
            FMT_RGB565:
            begin
                word_next  = {16'b0, px_in.r[7:3], px_in.g[7:2], px_in.b[7:3]};
                count_next = BYTES_TWO;
            end
            FMT_LA88:
            begin
                word_next  = {16'b0, px_in.a, lum_in};
                count_next = BYTES_TWO;
            end
            FMT_L8:
            begin
                word_next  = {24'b0, lum_in};
                count_next = BYTES_ONE;
            end
            default:
            begin
                // RGBA8, and unknown codes which fall back to it.
                word_next  = {px_in.a, px_in.b, px_in.g, px_in.r};
                count_next = BYTES_FOUR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
        last_reg  <= ctrl_in.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl_in.valid;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;
    assign count_out = count_reg;
    assign last_out  = last_reg;

endmodule : pfc_pack

`default_nettype wire

### tb/pixel_format_converter_tb.sv
// Self-checking testbench for the pixel format converter: directed corner pixels, then
// random pixels under every source/target format pair, checked against a scoreboard.
// Depends on pfc_pkg and pixel_format_converter.
`timescale 1ns / 1ps

module pixel_format_converter_tb;

    import pfc_pkg::*;

    // Codes outside the defined formats, which the block must still handle.
    localparam logic [2:0] FMT_SPARE_6 = 3'd6;
    localparam logic [2:0] FMT_SPARE_7 = 3'd7;

    localparam int PIPE_LATENCY   = 4;
    localparam int STALL_LIMIT    = 1000;
    localparam int PIXELS_PER_SET = 14;

    // One converted pixel as it should leave the block.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } converted_pixel_t;

    // Scoreboard: mirrors the format registers and holds the converted pixels still due.
    class pixel_scoreboard;
        logic [2:0]       src_fmt;
        logic [2:0]       tgt_fmt;
        converted_pixel_t pending_pixels[$];
        int               mismatches;
        int               pixels_in;
        int               results_seen;

        function new();
            src_fmt      = FMT_RGBA8;
            tgt_fmt      = FMT_RGBA8;
            mismatches   = 0;
            pixels_in    = 0;
            results_seen = 0;
        endfunction

        function void set_format(logic index, logic [2:0] value);
            if (index == CFG_SOURCE_FORMAT)
                src_fmt = value;
            else
                tgt_fmt = value;
        endfunction

        // Widen the source pixel to RGBA8; narrow colour channels are shifted up without
        // replicating bits, and a one-bit alpha becomes all ones or all zeros.
        function pfc_pixel_t unpack_to_rgba8(logic [31:0] w);
            pfc_pixel_t px;
            logic [15:0] h;
            h = w[15:0];
            case (src_fmt)
                FMT_RGBA8:
                begin
                    px.r = w[7:0];
                    px.g = w[15:8];
                    px.b = w[23:16];
                    px.a = w[31:24];
                end
                FMT_RGBA4:
                begin
                    px.r = {h[15:12], 4'b0};
                    px.g = {h[11:8], 4'b0};
                    px.b = {h[7:4], 4'b0};
                    px.a = {h[3:0], 4'b0};
                end
                FMT_RGB5_A1:
                begin
                    px.r = {h[15:11], 3'b0};
                    px.g = {h[10:6], 3'b0};
                    px.b = {h[5:1], 3'b0};
                    px.a = h[0] ? CHAN_FULL : 8'h00;
                end
                FMT_RGB565:
                begin
                    px.r = {h[15:11], 3'b0};
                    px.g = {h[10:5], 2'b0};
                    px.b = {h[4:0], 3'b0};
                    px.a = CHAN_FULL;
                end
                FMT_LA88:
                begin
                    px.r = w[7:0];
                    px.g = w[7:0];
                    px.b = w[7:0];
                    px.a = w[15:8];
                end
                FMT_L8:
                begin
                    px.r = w[7:0];
                    px.g = w[7:0];
                    px.b = w[7:0];
                    px.a = CHAN_FULL;
                end
                // An unknown source format expands to a fully clear pixel.
                default:
                begin
                    px = '0;
                end
            endcase
            return px;
        endfunction

        // Truncate each channel into the target layout; an unknown target packs as RGBA8.
        function converted_pixel_t pack_from_rgba8(pfc_pixel_t px);
            converted_pixel_t res;
            logic [9:0] sum;
            logic [9:0] lum;
            sum = 10'(px.r) + 10'(px.g) + 10'(px.b);
            lum = sum / 10'd3;
            res.word = '0;
            case (tgt_fmt)
                FMT_RGBA4:
                begin
                    res.word[15:0] = {px.r[7:4], px.g[7:4], px.b[7:4], px.a[7:4]};
                    res.count      = BYTES_TWO;
                end
                FMT_RGB5_A1:
                begin
                    res.word[15:0] = {px.r[7:3], px.g[7:3], px.b[7:3], px.a[7]};
                    res.count      = BYTES_TWO;
                end
                FMT_RGB565:
                begin
                    res.word[15:0] = {px.r[7:3], px.g[7:2], px.b[7:3]};
                    res.count      = BYTES_TWO;
                end
                FMT_LA88:
                begin
                    res.word[15:0] = {px.a, lum[7:0]};
                    res.count      = BYTES_TWO;
                end
                FMT_L8:
                begin
                    res.word[7:0] = lum[7:0];
                    res.count     = BYTES_ONE;
                end
                default:
                begin
                    res.word  = {px.a, px.b, px.g, px.r};
                    res.count = BYTES_FOUR;
                end
            endcase
            return res;
        endfunction

        function void note_pixel(logic [31:0] w, logic last);
            converted_pixel_t res;
            res      = pack_from_rgba8(unpack_to_rgba8(w));
            res.last = last;
            pending_pixels.push_back(res);
            pixels_in++;
        endfunction

        function void check_result(logic [31:0] word, logic [2:0] count, logic last);
            converted_pixel_t want;
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: result beat with no pixel outstanding, got word %h",
                         $time, word);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            if (word !== want.word)
            begin
                $display("%0t: dst_word mismatch, expected %h, got %h",
                         $time, want.word, word);
                mismatches++;
            end
            if (count !== want.count)
            begin
                $display("%0t: dst_byte_count mismatch, expected %0d, got %0d",
                         $time, want.count, count);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_out mismatch, expected %b, got %b",
                         $time, want.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_SOURCE_FORMAT;
    logic [2:0]  cfg_data  = '0;
    logic        start     = 1'b0;
    logic [31:0] src_word  = '0;
    logic        last_in   = 1'b0;
    logic        busy;
    logic        done;
    logic [31:0] dst_word;
    logic [2:0]  dst_byte_count;
    logic        last_out;

    pixel_scoreboard sb;
    int              stall_cycles = 0;
    bit              gaps_on      = 1'b1;
    logic [2:0]      cur_src      = FMT_RGBA8;
    logic [2:0]      cur_tgt      = FMT_RGBA8;

    pixel_format_converter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .src_word       (src_word),
        .last_in        (last_in),
        .done           (done),
        .dst_word       (dst_word),
        .dst_byte_count (dst_byte_count),
        .last_out       (last_out)
    );

    always #5 clk = ~clk;

    // Monitor: register writes, accepted pixels and result beats, all seen at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_format(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_pixel(src_word, last_in);
            if (done)
                sb.check_result(dst_word, dst_byte_count, last_out);
        end
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: give up when nothing has moved for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: timeout, no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Present one pixel, with random idle cycles ahead of it when gaps_on is set, and hold it until taken.
    // Start is left high so that back-to-back pixels keep it asserted.
    task automatic send_pixel(input logic [31:0] word, input logic last);
        while (gaps_on && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        src_word <= word;
        last_in  <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Let the pipeline empty, then write both format registers.
    task automatic set_formats(input logic [2:0] src, input logic [2:0] tgt);
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE_FORMAT;
        cfg_data  <= src;
        @(posedge clk);
        cfg_index <= CFG_TARGET_FORMAT;
        cfg_data  <= tgt;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_src  = src;
        cur_tgt  = tgt;
    endtask

    task automatic directed_pixel(input logic [2:0] src, input logic [2:0] tgt,
                                  input logic [31:0] word, input logic last);
        if (src != cur_src || tgt != cur_tgt)
            set_formats(src, tgt);
        send_pixel(word, last);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(19))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the reset formats first, then corners of each conversion.
        directed_pixel(FMT_RGBA8, FMT_RGBA8, 32'h0000_0000, 1'b0);
        directed_pixel(FMT_RGBA8, FMT_RGBA8, 32'hffff_ffff, 1'b1);
        directed_pixel(FMT_RGBA8, FMT_RGBA4, 32'h1234_5678, 1'b0);
        // The single alpha bit comes from the top bit of the 8-bit alpha.
        directed_pixel(FMT_RGBA8, FMT_RGB5_A1, 32'h7f80_ff01, 1'b0);
        directed_pixel(FMT_RGBA8, FMT_RGB5_A1, 32'h8000_0000, 1'b0);
        // RGB565 drops alpha altogether.
        directed_pixel(FMT_RGBA8, FMT_RGB565, 32'hffff_ffff, 1'b0);
        directed_pixel(FMT_RGBA8, FMT_LA88, 32'h00ff_ffff, 1'b0);
        directed_pixel(FMT_RGBA8, FMT_L8, 32'h00fe_fffe, 1'b0);
        directed_pixel(FMT_RGBA4, FMT_RGBA8, 32'h0000_ffff, 1'b0);
        directed_pixel(FMT_RGBA4, FMT_RGBA8, 32'hffff_0000, 1'b0);
        directed_pixel(FMT_RGB5_A1, FMT_RGBA8, 32'h0000_0001, 1'b0);
        directed_pixel(FMT_RGB5_A1, FMT_RGBA8, 32'h0000_fffe, 1'b0);
        directed_pixel(FMT_RGB565, FMT_RGBA8, 32'h0000_ffff, 1'b0);
        directed_pixel(FMT_RGB565, FMT_L8, 32'h0000_f800, 1'b0);
        directed_pixel(FMT_LA88, FMT_RGBA8, 32'h0000_ff00, 1'b0);
        directed_pixel(FMT_LA88, FMT_LA88, 32'h0000_00ff, 1'b1);
        directed_pixel(FMT_L8, FMT_RGBA8, 32'hffff_ff80, 1'b0);
        directed_pixel(FMT_L8, FMT_L8, 32'h0000_00ff, 1'b0);
        // Unknown source codes expand to a clear pixel.
        directed_pixel(FMT_SPARE_6, FMT_RGBA8, 32'hffff_ffff, 1'b0);
        directed_pixel(FMT_SPARE_7, FMT_LA88, 32'hffff_ffff, 1'b0);
        // Unknown target codes pack as RGBA8 with four bytes.
        directed_pixel(FMT_RGBA8, FMT_SPARE_6, 32'h1122_3344, 1'b0);
        directed_pixel(FMT_RGB565, FMT_SPARE_7, 32'h0000_ffff, 1'b0);
        directed_pixel(FMT_SPARE_6, FMT_SPARE_6, 32'h0000_0000, 1'b0);
        directed_pixel(FMT_L8, FMT_RGBA8, 32'h0000_0000, 1'b1);

        // Random part: every source/target pair, a long gap-free stretch in the middle.
        for (int s = 0; s < 8; s++)
        begin
            for (int t = 0; t < 8; t++)
            begin
                gaps_on = !(s == 3 || s == 4);
                set_formats(3'(s), 3'(t));
                for (int i = 0; i < PIXELS_PER_SET; i++)
                    send_pixel(random_word(), $urandom_range(7) == 0);
            end
        end
        gaps_on = 1'b1;

        // Drain the pipeline before judging.
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("Converted %0d pixels across all 64 source/target format pairs,",
                 sb.pixels_in);
        $display("unknown codes included; %0d result beats checked.", sb.results_seen);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
